// File: rtl/core/cmdlr_pkg.sv
// ----------------------------------------------------------------------------
// cmdlr_pkg
// Shared types and codes for the load-module record parser.
// ----------------------------------------------------------------------------
package cmdlr_pkg;

  localparam int ByteW = 8;
  localparam int AddrW = 16;
  localparam int CntW  = 9;
  localparam int KindW = 2;

  localparam logic [CntW-1:0] FullLength = 9'h100;
  localparam logic [CntW-1:0] ShortBias  = 9'h0fe;

  // result kinds
  localparam logic [KindW-1:0] KIND_WRITE = 2'd0;
  localparam logic [KindW-1:0] KIND_START = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR = 2'd2;
  localparam logic [KindW-1:0] KIND_STOP  = 2'd3;

  // record codes
  localparam logic [2:0] REC_OTHER = 3'd0;
  localparam logic [2:0] REC_DATA  = 3'd1;
  localparam logic [2:0] REC_EXEC  = 3'd2;
  localparam logic [2:0] REC_STOP  = 3'd3;

  typedef enum logic [3:0] {
    PH_CODE    = 4'd0,
    PH_LEN     = 4'd1,
    PH_ADDR_LO = 4'd2,
    PH_ADDR_HI = 4'd3,
    PH_PAYLOAD = 4'd4,
    PH_EXEC_LO = 4'd5,
    PH_EXEC_HI = 4'd6,
    PH_SKIP    = 4'd7,
    PH_STOPPED = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [2:0]        record_kind;
    logic [CntW-1:0]   record_length;
    logic [CntW-1:0]   bytes_left;
    logic [AddrW-1:0]  load_address;
    logic [ByteW-1:0]  start_low_byte;
  } parser_state_t;

  typedef struct packed {
    logic [ByteW-1:0] file_byte;
    logic             final_req;
  } in_beat_t;

  typedef struct packed {
    logic             emit;
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] address;
    logic [ByteW-1:0] data;
  } result_t;

endpackage

// File: rtl/core/cmdlr_in_reg.sv
// ----------------------------------------------------------------------------
// cmdlr_in_reg
// Input register for file bytes; stalls the source only while a held beat
// cannot move on to the parser step.
// ----------------------------------------------------------------------------
module cmdlr_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         file_byte,
  input  logic               final_req,
  input  logic               advance,
  output logic               held_valid,
  output cmdlr_pkg::in_beat_t held
);
  import cmdlr_pkg::*;

  logic load;

  assign byte_stall = held_valid && !advance;
  assign load       = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held.file_byte <= file_byte;
      held.final_req <= final_req;
    end
  end

endmodule

// File: rtl/core/cmdlr_step.sv
// ----------------------------------------------------------------------------
// cmdlr_step
// Next-state and result logic for one file byte of the record parser.
// ----------------------------------------------------------------------------
module cmdlr_step (
  input  cmdlr_pkg::parser_state_t cur,
  input  cmdlr_pkg::in_beat_t      beat,
  output cmdlr_pkg::parser_state_t nxt,
  output cmdlr_pkg::result_t       res
);
  import cmdlr_pkg::*;

  logic [ByteW-1:0] b;
  logic [CntW-1:0]  len_in;
  logic [CntW-1:0]  left_dec;

  assign b        = beat.file_byte;
  assign len_in   = (b == '0) ? FullLength : {1'b0, b};
  assign left_dec = cur.bytes_left - 9'd1;

  always_comb begin
    nxt         = cur;
    res.emit    = 1'b0;
    res.kind    = KIND_WRITE;
    res.address = '0;
    res.data    = '0;

    case (cur.phase)
      PH_LEN: begin
        nxt.record_length = len_in;
        if (cur.record_kind == REC_DATA) begin
          nxt.phase = PH_ADDR_LO;
        end else if (cur.record_kind == REC_EXEC) begin
          if (len_in == 9'd1 || len_in == 9'd2) begin
            nxt.phase = PH_EXEC_LO;
          end else begin
            res.emit       = 1'b1;
            res.kind       = KIND_ERROR;
            nxt.bytes_left = len_in;
            nxt.phase      = PH_SKIP;
          end
        end else begin
          nxt.bytes_left = len_in;
          nxt.phase      = PH_SKIP;
        end
      end
      PH_ADDR_LO: begin
        nxt.load_address = {8'h00, b};
        nxt.phase        = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        nxt.load_address = {b, cur.load_address[7:0]};
        // short lengths wrap around to a near-full payload
        nxt.bytes_left   = (cur.record_length < 9'd3) ? cur.record_length + ShortBias
                                                      : cur.record_length - 9'd2;
        nxt.phase        = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res.emit         = 1'b1;
        res.kind         = KIND_WRITE;
        res.address      = cur.load_address;
        res.data         = b;
        nxt.load_address = cur.load_address + 16'd1;
        nxt.bytes_left   = left_dec;
        if (left_dec == '0) nxt.phase = PH_CODE;
      end
      PH_EXEC_LO: begin
        if (cur.record_length == 9'd1) begin
          res.emit    = 1'b1;
          res.kind    = KIND_START;
          res.address = {8'h00, b};
          nxt.phase   = PH_CODE;
        end else begin
          nxt.start_low_byte = b;
          nxt.phase          = PH_EXEC_HI;
        end
      end
      PH_EXEC_HI: begin
        res.emit    = 1'b1;
        res.kind    = KIND_START;
        res.address = {b, cur.start_low_byte};
        nxt.phase   = PH_CODE;
      end
      PH_SKIP: begin
        nxt.bytes_left = left_dec;
        if (left_dec == '0) nxt.phase = PH_CODE;
      end
      PH_STOPPED: begin
        // hold until the final byte
      end
      default: begin
        if (b == {5'd0, REC_DATA} || b == {5'd0, REC_EXEC}) begin
          nxt.record_kind = b[2:0];
          nxt.phase       = PH_LEN;
        end else if (b == {5'd0, REC_STOP}) begin
          nxt.record_kind = REC_STOP;
          res.emit        = 1'b1;
          res.kind        = KIND_STOP;
          nxt.phase       = PH_STOPPED;
        end else begin
          nxt.record_kind = REC_OTHER;
          nxt.phase       = PH_LEN;
        end
      end
    endcase

    // final byte ends whatever record is open
    if (beat.final_req) begin
      nxt.phase      = PH_CODE;
      nxt.bytes_left = '0;
    end
  end

endmodule

// File: rtl/core/cmd_load_record_parser.sv
// ----------------------------------------------------------------------------
// cmd_load_record_parser
// Parses a load-module file byte stream into memory writes, start addresses,
// exec-record errors and stop markers.
// ----------------------------------------------------------------------------
//   channel  handshake              payload
//   byte     byte_valid/byte_stall  file_byte[7:0], final_req
//   rec      rec_valid/rec_stall    kind[1:0], address[15:0], data[7:0]
//
// One beat per cycle sustained while no stalled result is held. A byte
// lands in the input register; when it can advance, the step logic runs,
// updates parser state and loads the result register from that byte.
// Reset clears parser state and both valid flags. A stalled result holds
// the step, and the input register then stalls the byte side.
// ----------------------------------------------------------------------------
module cmd_load_record_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  file_byte,
  input  logic        final_req,
  output logic        rec_valid,
  input  logic        rec_stall,
  output logic [1:0]  kind,
  output logic [15:0] address,
  output logic [7:0]  data
);
  import cmdlr_pkg::*;

  logic          held_valid;
  in_beat_t      held;
  logic          advance;
  parser_state_t state;
  parser_state_t state_next;
  result_t       res;

  assign advance = held_valid && (!rec_valid || !rec_stall);

  cmdlr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .file_byte  (file_byte),
    .final_req  (final_req),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  cmdlr_step u_step (
    .cur  (state),
    .beat (held),
    .nxt  (state_next),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '{phase: PH_CODE, default: '0};
      rec_valid <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      rec_valid <= res.emit;
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      kind    <= res.kind;
      address <= res.address;
      data    <= res.data;
    end
  end

  a_stop_kind: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_STOPPED |-> state.record_kind == REC_STOP)
    else $error("stopped phase without a stop record");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_PAYLOAD || state.phase == PH_SKIP) |-> state.bytes_left != '0)
    else $error("payload or skip phase with no bytes left");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rec_valid && (kind == KIND_ERROR || kind == KIND_STOP) |-> address == '0 && data == '0)
    else $error("error or stop result with nonzero fields");

  a_rec_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_stall |=> rec_valid && $stable(kind) && $stable(address) && $stable(data))
    else $error("stalled result changed");

endmodule
